// File: src/preemptive_priority_scheduler_macros.svh
// ----------------------------------------------------------------------------
// Preemptive priority scheduler assertion macros
// Concurrent assertion wrappers that vanish in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH

`ifndef SYNTHESIS
`define PPS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PPS_ASSERT_ALL(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PPS_ASSERT(lbl, clk, rst_n, prop, msg)
`define PPS_ASSERT_ALL(lbl, clk, prop, msg)
`endif

`endif

// File: src/pps_pkg.sv
// ----------------------------------------------------------------------------
// Preemptive priority scheduler package
// Widths, item kinds and the command and status records shared by the block.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int MAX_PROCESSES = 16;
  localparam int IDX_W         = 4;
  localparam int CNT_W         = 5;
  localparam int ARR_W         = 16;
  localparam int BURST_W       = 16;
  localparam int PRIO_W        = 8;
  localparam int TIME_W        = 32;

  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_TICK    = 2'd1,
    KIND_RESTART = 2'd2
  } kind_e;

  typedef struct packed {
    logic load;
    logic restart;
    logic scan_init;
    logic scan_step;
    logic update;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic count_zero;
    logic out_busy;
  } ctrl_sts_t;

endpackage

// File: src/pps_in_if.sv
// ----------------------------------------------------------------------------
// Scheduler input channel
// Valid/ready channel carrying one load, tick or restart item.
// ----------------------------------------------------------------------------
interface pps_in_if;

  logic                          valid;
  logic                          ready;
  logic [1:0]                    kind;
  logic [pps_pkg::IDX_W-1:0]     entry_index;
  logic [pps_pkg::ARR_W-1:0]     arrive_tick;
  logic [pps_pkg::BURST_W-1:0]   service_ticks;
  logic [pps_pkg::PRIO_W-1:0]    priority_req;

  modport source (
    output valid, kind, entry_index, arrive_tick, service_ticks, priority_req,
    input  ready
  );

  modport sink (
    input  valid, kind, entry_index, arrive_tick, service_ticks, priority_req,
    output ready
  );

endinterface

// File: src/pps_out_if.sv
// ----------------------------------------------------------------------------
// Scheduler result channel
// Valid/ready channel carrying the report of one tick.
// ----------------------------------------------------------------------------
interface pps_out_if;

  logic                         valid;
  logic                         ready;
  logic [pps_pkg::TIME_W-1:0]   tick_time;
  logic [pps_pkg::IDX_W-1:0]    ran_index;
  logic                         idle;
  logic                         dispatched;
  logic                         finished;
  logic [pps_pkg::TIME_W-1:0]   first_run;
  logic [pps_pkg::TIME_W-1:0]   finish_tick;
  logic [pps_pkg::TIME_W-1:0]   turnaround;
  logic [pps_pkg::TIME_W-1:0]   wait_ticks;
  logic                         all_done;

  modport source (
    output valid, tick_time, ran_index, idle, dispatched, finished, first_run,
           finish_tick, turnaround, wait_ticks, all_done,
    input  ready
  );

  modport sink (
    input  valid, tick_time, ran_index, idle, dispatched, finished, first_run,
           finish_tick, turnaround, wait_ticks, all_done,
    output ready
  );

endinterface

// File: src/pps_ctrl.sv
// ----------------------------------------------------------------------------
// Scheduler controller
// Sequences item intake, the entry scan of a tick and the result update.
// ----------------------------------------------------------------------------
`include "preemptive_priority_scheduler_macros.svh"

module pps_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          in_kind_i,
  output logic                in_ready_o,
  input  pps_pkg::ctrl_sts_t  sts_i,
  output pps_pkg::ctrl_cmd_t  cmd_o
);
  import pps_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_kind_i)
            KIND_LOAD: begin
              cmd_o.load = 1'b1;
            end
            KIND_RESTART: begin
              cmd_o.restart = 1'b1;
            end
            KIND_TICK: begin
              cmd_o.scan_init = 1'b1;
              state_d = sts_i.count_zero ? ST_UPDATE : ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!sts_i.out_busy) begin
          cmd_o.update = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `PPS_ASSERT_ALL(a_cmd_onehot, clk_i, ($onehot0({cmd_o.load, cmd_o.restart, cmd_o.scan_init, cmd_o.scan_step, cmd_o.update})), "More than one datapath command at once.")
  `PPS_ASSERT(a_tick_leaves_idle, clk_i, rst_ni, (accept && in_kind_i == KIND_TICK) |=> (state_q != ST_IDLE), "A tick transfer did not start a scan.")
  `PPS_ASSERT(a_update_when_free, clk_i, rst_ni, cmd_o.update |-> (state_q == ST_UPDATE && !sts_i.out_busy), "Update issued while the result register is occupied.")

endmodule

// File: src/pps_datapath.sv
// ----------------------------------------------------------------------------
// Scheduler datapath
// Entry table, scan registers, run state and the result register.
// ----------------------------------------------------------------------------
`include "preemptive_priority_scheduler_macros.svh"

module pps_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pps_pkg::ctrl_cmd_t            cmd_i,
  output pps_pkg::ctrl_sts_t            sts_o,
  input  logic                          cfg_we_i,
  input  logic [pps_pkg::CNT_W-1:0]     cfg_data_i,
  input  logic [pps_pkg::IDX_W-1:0]     entry_index_i,
  input  logic [pps_pkg::ARR_W-1:0]     arrive_tick_i,
  input  logic [pps_pkg::BURST_W-1:0]   service_ticks_i,
  input  logic [pps_pkg::PRIO_W-1:0]    priority_req_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [pps_pkg::TIME_W-1:0]    tick_time_o,
  output logic [pps_pkg::IDX_W-1:0]     ran_index_o,
  output logic                          idle_o,
  output logic                          dispatched_o,
  output logic                          finished_o,
  output logic [pps_pkg::TIME_W-1:0]    first_run_o,
  output logic [pps_pkg::TIME_W-1:0]    finish_tick_o,
  output logic [pps_pkg::TIME_W-1:0]    turnaround_o,
  output logic [pps_pkg::TIME_W-1:0]    wait_ticks_o,
  output logic                          all_done_o
);
  import pps_pkg::*;

  logic [ARR_W-1:0]         arrival_q    [MAX_PROCESSES];
  logic [BURST_W-1:0]       burst_q      [MAX_PROCESSES];
  logic [PRIO_W-1:0]        prio_q       [MAX_PROCESSES];
  logic [BURST_W-1:0]       remaining_q  [MAX_PROCESSES];
  logic [TIME_W-1:0]        start_tick_q [MAX_PROCESSES];
  logic [MAX_PROCESSES-1:0] fresh_q;
  logic [MAX_PROCESSES-1:0] started_q;
  logic [MAX_PROCESSES-1:0] done_q;

  logic [CNT_W-1:0]  pc_q;
  logic [TIME_W-1:0] clock_q;
  logic              last_valid_q;
  logic [IDX_W-1:0]  last_q;

  logic [IDX_W-1:0]  idx_q;
  logic              found_q;
  logic [IDX_W-1:0]  best_q;
  logic [PRIO_W-1:0] best_prio_q;
  logic [TIME_W-1:0] best_turn_q;

  logic              out_valid_q;
  logic [TIME_W-1:0] out_tick_q;
  logic [IDX_W-1:0]  out_ran_q;
  logic              out_idle_q;
  logic              out_disp_q;
  logic              out_fin_q;
  logic [TIME_W-1:0] out_start_q;
  logic [TIME_W-1:0] out_comp_q;
  logic [TIME_W-1:0] out_turn_q;
  logic [TIME_W-1:0] out_wait_q;
  logic              out_all_q;

  logic [CNT_W-1:0]         count;
  logic                     eligible;
  logic                     take;
  logic [BURST_W-1:0]       rem_eff;
  logic                     finishing;
  logic                     dispatch;
  logic [TIME_W-1:0]        clock_inc;
  logic [MAX_PROCESSES-1:0] best_onehot;
  logic [MAX_PROCESSES-1:0] done_next;
  logic [MAX_PROCESSES-1:0] use_mask;
  logic                     all_done_c;

  assign count = (pc_q > CNT_W'(MAX_PROCESSES)) ? CNT_W'(MAX_PROCESSES) : pc_q;

  assign sts_o.scan_last  = ({1'b0, idx_q} == (count - CNT_W'(1)));
  assign sts_o.count_zero = (count == '0);
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;

  assign eligible = !done_q[idx_q] && ({{(TIME_W-ARR_W){1'b0}}, arrival_q[idx_q]} <= clock_q);
  assign take     = eligible && (!found_q || (prio_q[idx_q] > best_prio_q));

  assign rem_eff     = fresh_q[best_q] ? burst_q[best_q] : remaining_q[best_q];
  assign finishing   = found_q && (rem_eff <= BURST_W'(1));
  assign dispatch    = found_q && (!last_valid_q || (last_q != best_q));
  assign clock_inc   = clock_q + TIME_W'(1);
  assign best_onehot = MAX_PROCESSES'(1) << best_q;
  assign done_next   = finishing ? (done_q | best_onehot) : done_q;

  always_comb begin
    for (int i = 0; i < MAX_PROCESSES; i++) begin
      use_mask[i] = (CNT_W'(i) < count);
    end
  end

  assign all_done_c = &(done_next | ~use_mask);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q         <= '0;
      clock_q      <= '0;
      last_valid_q <= 1'b0;
      fresh_q      <= '0;
      started_q    <= '0;
      done_q       <= '0;
      found_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        pc_q <= cfg_data_i;
      end
      if (cmd_i.load) begin
        fresh_q[entry_index_i]   <= 1'b1;
        started_q[entry_index_i] <= 1'b0;
        done_q[entry_index_i]    <= 1'b0;
      end
      if (cmd_i.restart) begin
        fresh_q      <= '1;
        started_q    <= '0;
        done_q       <= '0;
        clock_q      <= '0;
        last_valid_q <= 1'b0;
      end
      if (cmd_i.scan_init) begin
        found_q <= 1'b0;
      end else if (cmd_i.scan_step && take) begin
        found_q <= 1'b1;
      end
      if (cmd_i.update) begin
        clock_q <= clock_inc;
        done_q  <= done_next;
        if (found_q) begin
          started_q[best_q] <= 1'b1;
          fresh_q[best_q]   <= 1'b0;
          if (finishing) begin
            last_valid_q <= 1'b0;
          end else if (dispatch) begin
            last_valid_q <= 1'b1;
          end
        end
      end
      if (cmd_i.update) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      arrival_q[entry_index_i] <= arrive_tick_i;
      burst_q[entry_index_i]   <= service_ticks_i;
      prio_q[entry_index_i]    <= priority_req_i;
    end
    if (cmd_i.scan_init) begin
      idx_q <= '0;
    end else if (cmd_i.scan_step) begin
      idx_q <= idx_q + IDX_W'(1);
      if (take) begin
        best_q      <= idx_q;
        best_prio_q <= prio_q[idx_q];
        best_turn_q <= clock_inc - {{(TIME_W-ARR_W){1'b0}}, arrival_q[idx_q]};
      end
    end
    if (cmd_i.update) begin
      if (found_q) begin
        if (!started_q[best_q]) begin
          start_tick_q[best_q] <= clock_q;
        end
        remaining_q[best_q] <= finishing ? '0 : (rem_eff - BURST_W'(1));
        if (dispatch) begin
          last_q <= best_q;
        end
      end
      out_tick_q  <= clock_q;
      out_ran_q   <= found_q ? best_q : '0;
      out_idle_q  <= !found_q;
      out_disp_q  <= dispatch;
      out_fin_q   <= finishing;
      out_start_q <= finishing ? (started_q[best_q] ? start_tick_q[best_q] : clock_q) : '0;
      out_comp_q  <= finishing ? clock_inc : '0;
      out_turn_q  <= finishing ? best_turn_q : '0;
      out_wait_q  <= finishing ?
                     (best_turn_q - {{(TIME_W-BURST_W){1'b0}}, burst_q[best_q]}) : '0;
      out_all_q   <= all_done_c;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign tick_time_o   = out_tick_q;
  assign ran_index_o   = out_ran_q;
  assign idle_o        = out_idle_q;
  assign dispatched_o  = out_disp_q;
  assign finished_o    = out_fin_q;
  assign first_run_o   = out_start_q;
  assign finish_tick_o = out_comp_q;
  assign turnaround_o  = out_turn_q;
  assign wait_ticks_o  = out_wait_q;
  assign all_done_o    = out_all_q;

  `PPS_ASSERT(a_result_from_update, clk_i, rst_ni, $rose(out_valid_q) |-> $past(cmd_i.update), "Result appeared without an update.")
  `PPS_ASSERT(a_finish_marks_done, clk_i, rst_ni, (cmd_i.update && finishing) |=> done_q[$past(best_q)], "A finished entry was not marked done.")
  `PPS_ASSERT(a_idle_keeps_last, clk_i, rst_ni, (cmd_i.update && !found_q) |=> $stable(last_valid_q), "An idle tick changed the running entry record.")

endmodule

// File: src/preemptive_priority_scheduler.sv
// ----------------------------------------------------------------------------
// Preemptive priority scheduler
// Process table with a per-tick highest-priority selection and timing report.
// ----------------------------------------------------------------------------
// Load and restart items are taken in the idle state and produce no result.
// A tick item is taken, then the priority scan reads the first count table
// entries, a single entry per cycle, where count is process_count limited
// to the table size of 16, and then the entry is updated and the result
// register written. The next item is taken while a result still waits in
// that register; a later tick holds in its update state until the register
// is free.

module preemptive_priority_scheduler (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [pps_pkg::CNT_W-1:0]  cfg_data_i,
  pps_in_if.sink                     in_i,
  pps_out_if.source                  out_o
);
  import pps_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  pps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_kind_i  (in_i.kind),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pps_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .entry_index_i   (in_i.entry_index),
    .arrive_tick_i   (in_i.arrive_tick),
    .service_ticks_i (in_i.service_ticks),
    .priority_req_i  (in_i.priority_req),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .tick_time_o     (out_o.tick_time),
    .ran_index_o     (out_o.ran_index),
    .idle_o          (out_o.idle),
    .dispatched_o    (out_o.dispatched),
    .finished_o      (out_o.finished),
    .first_run_o     (out_o.first_run),
    .finish_tick_o   (out_o.finish_tick),
    .turnaround_o    (out_o.turnaround),
    .wait_ticks_o    (out_o.wait_ticks),
    .all_done_o      (out_o.all_done)
  );

endmodule

// File: dv/preemptive_priority_scheduler_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Preemptive priority scheduler testbench
// Drives load, tick and restart items through the input channel with bursty
// traffic, while the result channel stalls on random patterns. A predictor
// of the process table computes the expected report of every tick, and each
// report transfer is checked field by field against the oldest prediction.
// Directed tests come first, followed by random scheduling runs under many
// process counts.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_tb;

  import pps_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int         ITEM_TARGET = 1950;
  localparam int         SETTLE_CYCLES = 24;

  typedef struct {
    logic [1:0]         kind;
    logic [IDX_W-1:0]   entry;
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
  } sched_item_t;

  typedef struct {
    logic [TIME_W-1:0] tick_time;
    logic [IDX_W-1:0]  ran_index;
    logic              idle;
    logic              dispatched;
    logic              finished;
    logic [TIME_W-1:0] first_run;
    logic [TIME_W-1:0] finish_tick;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] wait_ticks;
    logic              all_done;
  } tick_report_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CNT_W-1:0] cfg_data_i;

  pps_in_if  in_if ();
  pps_out_if out_if ();

  preemptive_priority_scheduler dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predicted process table.
  logic [ARR_W-1:0]   arr_tick    [MAX_PROCESSES];
  logic [BURST_W-1:0] burst_len   [MAX_PROCESSES];
  logic [PRIO_W-1:0]  prio_lvl    [MAX_PROCESSES];
  logic [BURST_W-1:0] left_ticks  [MAX_PROCESSES];
  logic               has_started [MAX_PROCESSES];
  logic [TIME_W-1:0]  first_tick  [MAX_PROCESSES];
  logic               is_done     [MAX_PROCESSES];
  logic [TIME_W-1:0]  sched_clock;
  logic               prev_valid;
  logic [IDX_W-1:0]   prev_entry;
  logic [CNT_W-1:0]   proc_count;

  tick_report_t expected_reports[$];
  bit           loaded_once[MAX_PROCESSES];
  int           error_count;
  int           item_total;
  int           burst_left;
  bit           sender_gaps;

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic int active_entries();
    return (proc_count > MAX_PROCESSES) ? MAX_PROCESSES : int'(proc_count);
  endfunction

  function automatic bit active_all_done();
    bit all;
    all = 1'b1;
    for (int i = 0; i < active_entries(); i++) if (!is_done[i]) all = 1'b0;
    return all;
  endfunction

  function automatic void arm_entry(input int i);
    left_ticks[i]  = burst_len[i];
    has_started[i] = 1'b0;
    first_tick[i]  = '0;
    is_done[i]     = 1'b0;
  endfunction

  function automatic void schedule_item(input sched_item_t it);
    tick_report_t rep;
    bit           found;
    int           best;
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] turn;
    found = 1'b0;
    best  = 0;
    case (it.kind)
      KIND_LOAD: begin
        arr_tick[it.entry]  = it.arrival;
        burst_len[it.entry] = it.burst;
        prio_lvl[it.entry]  = it.prio;
        arm_entry(int'(it.entry));
      end
      KIND_RESTART: begin
        for (int i = 0; i < MAX_PROCESSES; i++) arm_entry(i);
        sched_clock = '0;
        prev_valid  = 1'b0;
        prev_entry  = '0;
      end
      KIND_TICK: begin
        rep = '{default: '0};
        for (int i = 0; i < active_entries(); i++) begin
          if (!is_done[i] && TIME_W'(arr_tick[i]) <= sched_clock) begin
            if (!found || prio_lvl[i] > prio_lvl[best]) begin
              found = 1'b1;
              best  = i;
            end
          end
        end
        t = sched_clock;
        rep.tick_time = t;
        sched_clock = t + TIME_W'(1);
        if (!found) begin
          rep.idle = 1'b1;
        end else begin
          rep.ran_index = best[IDX_W-1:0];
          if (!has_started[best]) begin
            has_started[best] = 1'b1;
            first_tick[best]  = t;
          end
          if (!prev_valid || prev_entry != best[IDX_W-1:0]) begin
            rep.dispatched = 1'b1;
            prev_valid     = 1'b1;
            prev_entry     = best[IDX_W-1:0];
          end
          if (left_ticks[best] <= 1) begin
            turn = sched_clock - TIME_W'(arr_tick[best]);
            left_ticks[best] = '0;
            is_done[best]    = 1'b1;
            prev_valid       = 1'b0;
            rep.finished     = 1'b1;
            rep.first_run    = first_tick[best];
            rep.finish_tick  = sched_clock;
            rep.turnaround   = turn;
            rep.wait_ticks   = turn - TIME_W'(burst_len[best]);
          end else begin
            left_ticks[best] = left_ticks[best] - BURST_W'(1);
          end
        end
        rep.all_done = active_all_done();
        expected_reports.push_back(rep);
      end
      default: ;
    endcase
  endfunction

  // Sends one item and returns at the edge where its transfer happens,
  // or after the idle gap that follows it.
  task automatic send_item(input sched_item_t it);
    int gap;
    gap = 0;
    in_if.valid         <= 1'b1;
    in_if.kind          <= it.kind;
    in_if.entry_index   <= it.entry;
    in_if.arrive_tick   <= it.arrival;
    in_if.service_ticks <= it.burst;
    in_if.priority_req  <= it.prio;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    schedule_item(it);
    if (it.kind != KIND_UNUSED) item_total++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      if (sender_gaps) gap = $urandom_range(1, 6);
    end
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_load(input logic [IDX_W-1:0] e, input logic [ARR_W-1:0] arrival,
                           input logic [BURST_W-1:0] burst, input logic [PRIO_W-1:0] prio);
    sched_item_t it;
    it = '{kind: KIND_LOAD, entry: e, arrival: arrival, burst: burst, prio: prio};
    loaded_once[e] = 1'b1;
    send_item(it);
  endtask

  task automatic send_tick();
    sched_item_t it;
    it = '{kind: KIND_TICK, entry: IDX_W'($urandom), arrival: ARR_W'($urandom),
           burst: BURST_W'($urandom), prio: PRIO_W'($urandom)};
    send_item(it);
  endtask

  task automatic send_restart();
    sched_item_t it;
    it = '{kind: KIND_RESTART, entry: IDX_W'($urandom), arrival: ARR_W'($urandom),
           burst: BURST_W'($urandom), prio: PRIO_W'($urandom)};
    send_item(it);
  endtask

  task automatic send_noise();
    sched_item_t it;
    it = '{kind: KIND_UNUSED, entry: IDX_W'($urandom), arrival: ARR_W'($urandom),
           burst: BURST_W'($urandom), prio: PRIO_W'($urandom)};
    send_item(it);
  endtask

  task automatic send_random_load(input logic [IDX_W-1:0] e);
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    if ($urandom_range(15) == 0) arrival = ARR_W'($urandom);
    else arrival = ARR_W'(sched_clock + $urandom_range(0, 12));
    case ($urandom_range(15))
      0:       burst = BURST_W'($urandom);
      1:       burst = '0;
      default: burst = BURST_W'($urandom_range(1, 6));
    endcase
    case ($urandom_range(5))
      0:       prio = '0;
      1:       prio = '1;
      2:       prio = PRIO_W'($urandom_range(3));
      default: prio = PRIO_W'($urandom);
    endcase
    send_load(e, arrival, burst, prio);
  endtask

  // Waits until every predicted report has been seen and the block has
  // had time to finish any load or restart.
  task automatic quiesce();
    int waited;
    waited = 0;
    in_if.valid <= 1'b0;
    while (expected_reports.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_count(input logic [CNT_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    proc_count = value;
  endtask

  task automatic compare_field(input logic [TIME_W-1:0] tick, input string name,
                               input logic [TIME_W-1:0] got, input logic [TIME_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("tick %0d %s: got %0h, expected %0h", tick, name, got, want));
  endtask

  task automatic check_report();
    tick_report_t want;
    if (expected_reports.size() == 0) begin
      report_mismatch("report transfer with no tick outstanding");
    end else begin
      want = expected_reports.pop_front();
      compare_field(want.tick_time, "tick_time", out_if.tick_time, want.tick_time);
      compare_field(want.tick_time, "ran_index", TIME_W'(out_if.ran_index),
                    TIME_W'(want.ran_index));
      compare_field(want.tick_time, "idle", TIME_W'(out_if.idle), TIME_W'(want.idle));
      compare_field(want.tick_time, "dispatched", TIME_W'(out_if.dispatched),
                    TIME_W'(want.dispatched));
      compare_field(want.tick_time, "finished", TIME_W'(out_if.finished),
                    TIME_W'(want.finished));
      compare_field(want.tick_time, "first_run", out_if.first_run, want.first_run);
      compare_field(want.tick_time, "finish_tick", out_if.finish_tick, want.finish_tick);
      compare_field(want.tick_time, "turnaround", out_if.turnaround, want.turnaround);
      compare_field(want.tick_time, "wait_ticks", out_if.wait_ticks, want.wait_ticks);
      compare_field(want.tick_time, "all_done", TIME_W'(out_if.all_done),
                    TIME_W'(want.all_done));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) check_report();
  end

  logic [15:0] stall_pat;
  int          stall_pos = 0;

  always @(posedge clk_i) begin
    if (stall_pos == 0) begin
      if ($urandom_range(3) == 0) stall_pat = 16'hFFFF;
      else stall_pat = 16'($urandom) | 16'h0001;
    end
    out_if.ready <= stall_pat[stall_pos];
    stall_pos = (stall_pos + 1) % 16;
  end

  task automatic test_empty_table();
    send_tick();
  endtask

  task automatic test_priority_ties();
    quiesce();
    write_count(CNT_W'(3));
    send_load(4'd0, 16'd0, 16'd2, 8'd5);
    send_load(4'd1, 16'd0, 16'd1, 8'd5);
    send_load(4'd2, 16'd1, 16'd1, 8'd255);
    repeat (5) send_tick();
  endtask

  task automatic test_zero_burst_idle();
    send_restart();
    send_load(4'd0, 16'd2, 16'd0, 8'd0);
    send_load(4'd1, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_load(4'd2, 16'd3, 16'd0, 8'd128);
    repeat (5) send_tick();
  endtask

  task automatic test_reload_done();
    send_load(4'd0, 16'd0, 16'd1, 8'd0);
    send_tick();
  endtask

  task automatic test_unused_kind();
    send_noise();
    send_tick();
  endtask

  task automatic test_random_runs();
    int               phase;
    int               cap;
    int               ticks;
    int               r;
    int               act;
    logic [CNT_W-1:0] cnt;
    phase = 0;
    while (item_total < ITEM_TARGET) begin
      quiesce();
      case (phase)
        0: cnt = CNT_W'(16);
        1: cnt = CNT_W'(31);
        2: cnt = CNT_W'(0);
        default: begin
          r = $urandom_range(99);
          if (r < 50) cnt = CNT_W'($urandom_range(1, 8));
          else if (r < 70) cnt = CNT_W'($urandom_range(9, 16));
          else if (r < 85) cnt = CNT_W'($urandom_range(17, 31));
          else cnt = ($urandom_range(1) == 0) ? CNT_W'(0) : CNT_W'(31);
        end
      endcase
      write_count(cnt);
      sender_gaps = ($urandom_range(3) != 0);
      act = active_entries();
      if (phase < 3 || $urandom_range(3) != 0) send_restart();
      for (int e = 0; e < MAX_PROCESSES; e++) begin
        if ((e < act && (!loaded_once[e] || $urandom_range(2) != 0)) ||
            $urandom_range(7) == 0)
          send_random_load(e[IDX_W-1:0]);
      end
      ticks = 0;
      cap = $urandom_range(40, 90);
      while (!active_all_done() && ticks < cap) begin
        r = $urandom_range(99);
        if (r < 84) begin
          send_tick();
          ticks++;
        end else if (r < 93) begin
          send_random_load(IDX_W'($urandom_range(15)));
        end else if (r < 97) begin
          send_noise();
        end else begin
          send_restart();
        end
      end
      repeat ($urandom_range(1, 3)) send_tick();
      phase++;
    end
  endtask

  initial begin
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_data_i          = '0;
    in_if.valid         = 1'b0;
    in_if.kind          = KIND_LOAD;
    in_if.entry_index   = '0;
    in_if.arrive_tick   = '0;
    in_if.service_ticks = '0;
    in_if.priority_req  = '0;
    out_if.ready        = 1'b0;
    for (int i = 0; i < MAX_PROCESSES; i++) begin
      arr_tick[i]    = '0;
      burst_len[i]   = '0;
      prio_lvl[i]    = '0;
      left_ticks[i]  = '0;
      has_started[i] = 1'b0;
      first_tick[i]  = '0;
      is_done[i]     = 1'b0;
      loaded_once[i] = 1'b0;
    end
    sched_clock = '0;
    prev_valid  = 1'b0;
    prev_entry  = '0;
    proc_count  = '0;
    error_count = 0;
    item_total  = 0;
    burst_left  = 0;
    sender_gaps = 1'b1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_priority_ties();
    test_zero_burst_idle();
    test_reload_done();
    test_unused_kind();
    test_random_runs();

    quiesce();
    if (expected_reports.size() != 0)
      report_mismatch($sformatf("%0d tick reports never arrived", expected_reports.size()));
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
